FILE: rtl/mmcm_pkg.sv
// Shared types and constants for the min/max normalizing color mapper.
package mmcm_pkg;

   // Quotient width of the range divider (full 24-bit color scale)
   localparam int QUOT_BITS = 24;
   // Grey scale is 2^GREY_BITS - 1
   localparam int GREY_BITS = 8;
   // Width of one color channel
   localparam int CHAN_BITS = 8;

   // Operation codes carried on the request tuser
   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_MAP     = 1'b1;

   // Lookup modes
   localparam logic MODE_GREY = 1'b0;
   localparam logic MODE_RGB  = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WORK,
      ST_START,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/minmax_normalize_colour_map.sv
// Auto-contrast color mapper: running min/max tracking and range normalization.
//
// Request beats carry a sample and an operation. A measure beat folds the
// sample into the running minimum and maximum (tuser bit 1 restarts both
// from the sample). A map beat returns floor(scale*(v-min)/(max-min)) as a
// color: scale 255 on all three channels in grey mode, 0xFFFFFF split into
// red/green/blue bytes in RGB mode. Flat range or v <= min gives 0, v >= max
// gives full scale. Every request beat yields exactly one response beat that
// also reports the range after the beat and a flat-range flag.
// The one-bit csr register selects grey (0) or RGB (1); write it while idle.
// Sequence: a beat is accepted in idle and evaluated in work; a map beat
// that needs division then starts the radix-2 divider, which produces one
// quotient bit per cycle over 24 bits, and waits for it. Saturated and flat
// map beats and measure beats go straight to done. One beat is in work at a
// time: the next request is accepted in the cycle after the response loads.
// The response sits in an output register: the next request is accepted and
// processed while it waits, and a stalled receiver holds the block only when
// a second result is ready to load. Reset clears the range to 0/0, the mode
// to grey and drops all valids.
module minmax_normalize_colour_map #(
   parameter int SAMPLE_BITS = 16,
   localparam int ReqDataBits = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RspDataBits = ((3 * mmcm_pkg::CHAN_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,   // lut_mode
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ReqDataBits-1:0] req_tdata,     // sample
   input  logic [1:0]             req_tuser,     // operation, first
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataBits-1:0] rsp_tdata,     // red, green, blue, range_low, range_high
   output logic                   rsp_tuser      // flat_range
);
   import mmcm_pkg::*;

   localparam int ColorBits = 3 * CHAN_BITS;

   state_type                     state_ff, state_in;
   logic                          mode_ff;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic                          op_ff, op_in;
   logic                          first_ff, first_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [SAMPLE_BITS-1:0]        off_ff, off_in;
   logic [SAMPLE_BITS-1:0]        span_ff, span_in;
   logic [ColorBits-1:0]          color_ff, color_in;

   logic                          out_valid_ff, out_valid_in;
   logic [ColorBits-1:0]          out_color_ff, out_color_in;
   logic [SAMPLE_BITS-1:0]        out_low_ff, out_low_in;
   logic [SAMPLE_BITS-1:0]        out_high_ff, out_high_in;
   logic                          out_flat_ff, out_flat_in;

   logic signed [SAMPLE_BITS:0]   off_wide;
   logic signed [SAMPLE_BITS:0]   span_wide;
   logic                          div_start;
   logic                          div_done;
   logic [QUOT_BITS-1:0]          div_quot;

   // Offset and span of the sample against the latched range
   always_comb begin
      off_wide  = {sample_ff[SAMPLE_BITS-1], sample_ff} - {min_ff[SAMPLE_BITS-1], min_ff};
      span_wide = {max_ff[SAMPLE_BITS-1], max_ff} - {min_ff[SAMPLE_BITS-1], min_ff};
   end

   // Sequencer: next state, datapath loads and output register
   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      op_in        = op_ff;
      first_in     = first_ff;
      sample_in    = sample_ff;
      off_in       = off_ff;
      span_in      = span_ff;
      color_in     = color_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_color_in = out_color_ff;
      out_low_in   = out_low_ff;
      out_high_in  = out_high_ff;
      out_flat_in  = out_flat_ff;
      req_tready   = 1'b0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in     = req_tuser[0];
               first_in  = req_tuser[1];
               sample_in = req_tdata[SAMPLE_BITS-1:0];
               state_in  = ST_WORK;
            end
         end
         ST_WORK: begin
            off_in  = off_wide[SAMPLE_BITS-1:0];
            span_in = span_wide[SAMPLE_BITS-1:0];
            if (op_ff == OP_MEASURE) begin
               color_in = '0;
               if (first_ff) begin
                  min_in = sample_ff;
                  max_in = sample_ff;
               end else begin
                  if (sample_ff < min_ff) min_in = sample_ff;
                  if (sample_ff > max_ff) max_in = sample_ff;
               end
               state_in = ST_DONE;
            end else if (max_ff <= min_ff || sample_ff <= min_ff) begin
               // flat range or at/below minimum
               color_in = '0;
               state_in = ST_DONE;
            end else if (sample_ff >= max_ff) begin
               // full scale is all ones in both modes
               color_in = '1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               color_in = (mode_ff == MODE_RGB) ? div_quot
                                                : {3{div_quot[CHAN_BITS-1:0]}};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_color_in = color_ff;
               out_low_in   = min_ff;
               out_high_in  = max_ff;
               out_flat_in  = (min_ff == max_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and range registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
      end
   end

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GREY;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      first_ff     <= first_in;
      sample_ff    <= sample_in;
      off_ff       <= off_in;
      span_ff      <= span_in;
      color_ff     <= color_in;
      out_color_ff <= out_color_in;
      out_low_ff   <= out_low_in;
      out_high_ff  <= out_high_in;
      out_flat_ff  <= out_flat_in;
   end

   mmcm_divider #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rgb_mode (mode_ff),
      .offset   (off_ff),
      .span     (span_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Response beat: red in the low byte, then green, blue, low, high
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_flat_ff;
   assign rsp_tdata  = RspDataBits'({out_high_ff, out_low_ff,
                                     out_color_ff[CHAN_BITS-1:0],
                                     out_color_ff[2*CHAN_BITS-1:CHAN_BITS],
                                     out_color_ff[ColorBits-1:2*CHAN_BITS]});

   // Range stays ordered
   assert property (@(posedge clock) disable iff (reset) min_ff <= max_ff)
      else $error("running minimum above running maximum");

   // Divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset) div_done |-> state_ff == ST_DIVIDE)
      else $error("divider done outside divide state");

   // Flat flag matches the reported range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (out_low_ff == out_high_ff)))
      else $error("flat flag disagrees with range");

   // Flat range always carries a black color
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (out_color_ff == '0))
      else $error("nonzero color on flat range");

endmodule

FILE: rtl/mmcm_divider.sv
// Radix-2 restoring divider: floor(scale * offset / span), one quotient bit per cycle.
module mmcm_divider #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             rgb_mode,
   input  logic [SAMPLE_BITS-1:0]           offset,
   input  logic [SAMPLE_BITS-1:0]           span,     // held stable while busy
   output logic                             done,
   output logic [mmcm_pkg::QUOT_BITS-1:0]   quotient
);
   import mmcm_pkg::*;

   localparam int ProdBits  = SAMPLE_BITS + QUOT_BITS;
   localparam int CountBits = $clog2(QUOT_BITS + 1);

   logic [ProdBits-1:0]    off_ext;
   logic [ProdBits-1:0]    prod_scaled;
   logic [ProdBits-1:0]    prod;
   logic [SAMPLE_BITS:0]   trial;
   logic [SAMPLE_BITS:0]   diff;
   logic                   fits;

   logic [SAMPLE_BITS-1:0] rem_ff,  rem_in;
   logic [QUOT_BITS-1:0]   num_ff,  num_in;
   logic [QUOT_BITS-1:0]   quot_ff, quot_in;
   logic [CountBits-1:0]   cnt_ff,  cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   // Dividend scale*offset as a shift and subtract: offset * (2^k - 1)
   always_comb begin
      off_ext     = ProdBits'(offset);
      prod_scaled = (rgb_mode == MODE_RGB) ? (off_ext << QUOT_BITS) : (off_ext << GREY_BITS);
      prod        = prod_scaled - off_ext;
   end

   // Trial subtract of one partial remainder
   always_comb begin
      trial = {rem_ff, num_ff[QUOT_BITS-1]};
      diff  = trial - {1'b0, span};
      fits  = (trial >= {1'b0, span});
   end

   // Next values: load on start, else shift one bit per cycle while busy
   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // top bits are below span since offset < span
         rem_in  = prod[ProdBits-1:QUOT_BITS];
         num_in  = prod[QUOT_BITS-1:0];
         quot_in = '0;
         cnt_in  = CountBits'(QUOT_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
         num_in  = {num_ff[QUOT_BITS-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_BITS-2:0], fits};
         cnt_in  = cnt_ff - CountBits'(1);
         if (cnt_ff == CountBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath shift registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

FILE: test/tb_minmax_normalize_colour_map.sv
// Self-checking testbench for the min/max normalizing color mapper.
`timescale 1ns / 100ps

module tb_minmax_normalize_colour_map;
   import mmcm_pkg::*;

   localparam int SampleBits = 16;
   localparam int RspBits    = 56;

   // one expected response beat
   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] range_low;
      logic [15:0] range_high;
      logic        flat_range;
   } colour_beat_type;

   // tracks the running range and mode, predicts colors, checks responses
   class colour_scoreboard;
      logic signed [15:0] range_low  = '0;
      logic signed [15:0] range_high = '0;
      logic               lut_mode   = MODE_GREY;
      colour_beat_type    colour_q[$];
      int                 errors     = 0;
      int                 checked    = 0;
      int                 maps       = 0;

      function void set_mode(logic m);
         lut_mode = m;
      endfunction

      // floor(scale * (v - min) / (max - min)) with saturation
      function longint unsigned normalize(logic signed [15:0] voxel,
                                          longint unsigned scale);
         longint lo, hi, v;
         lo = range_low;
         hi = range_high;
         v  = voxel;
         if (hi <= lo) return 0;
         if (v <= lo) return 0;
         if (v >= hi) return scale;
         return (scale * longint'(v - lo)) / longint'(hi - lo);
      endfunction

      function void note_request(logic op, logic [15:0] raw, logic first_flag);
         logic signed [15:0] voxel;
         longint unsigned    level;
         colour_beat_type    beat;
         voxel = raw;
         beat  = '0;
         if (op == OP_MEASURE) begin
            if (first_flag) begin
               range_low  = voxel;
               range_high = voxel;
            end else begin
               if (voxel < range_low)  range_low  = voxel;
               if (voxel > range_high) range_high = voxel;
            end
         end else begin
            maps++;
            if (lut_mode == MODE_GREY) begin
               level      = normalize(voxel, 64'hff);
               beat.red   = level[7:0];
               beat.green = level[7:0];
               beat.blue  = level[7:0];
            end else begin
               level      = normalize(voxel, 64'hff_ffff);
               beat.red   = level[23:16];
               beat.green = level[15:8];
               beat.blue  = level[7:0];
            end
         end
         beat.range_low  = range_low;
         beat.range_high = range_high;
         beat.flat_range = (range_low == range_high);
         colour_q.push_back(beat);
      endfunction

      function void check_field(string name, logic [15:0] exp, logic [15:0] act);
         if (act !== exp) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
         end
      endfunction

      function void check_response(logic [RspBits-1:0] data, logic flat);
         colour_beat_type exp;
         if (colour_q.size() == 0) begin
            errors++;
            $display("%0t: response beat with nothing expected, expected none, got %h/%b",
                     $time, data, flat);
            return;
         end
         exp = colour_q.pop_front();
         checked++;
         check_field("red",        exp.red,        data[7:0]);
         check_field("green",      exp.green,      data[15:8]);
         check_field("blue",       exp.blue,       data[23:16]);
         check_field("range_low",  exp.range_low,  data[39:24]);
         check_field("range_high", exp.range_high, data[55:40]);
         check_field("flat_range", exp.flat_range, flat);
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic                  csr_wr_data = 1'b0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [SampleBits-1:0] req_tdata   = '0;
   logic [1:0]            req_tuser   = '0;   // operation, first
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RspBits-1:0]    rsp_tdata;          // red, green, blue, range_low, range_high
   logic                  rsp_tuser;          // flat_range

   colour_scoreboard sb = new;
   int  items_sent  = 0;
   int  stall_left  = 0;
   int  grey_phases = 0;
   int  rgb_phases  = 0;
   bit  send_calm   = 1'b0;
   bit  rsp_calm    = 1'b0;

   minmax_normalize_colour_map #(.SAMPLE_BITS(SampleBits)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #6 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // response side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata, rsp_tuser);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_calm || $urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // drive one request beat and hold it until accepted
   task automatic send_beat(logic op, logic [15:0] voxel, logic first_flag);
      req_tvalid <= 1'b1;
      req_tdata  <= voxel;
      req_tuser  <= {first_flag, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, voxel, first_flag);
      items_sent++;
      if (!send_calm && $urandom_range(0, 2) == 0) pause_sender(pick_gap());
   endtask

   // let every expected beat come back, then a few idle cycles
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.colour_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(logic m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_mode(m);
      if (m == MODE_RGB) rgb_phases++;
      else grey_phases++;
   endtask

   // restart the range, widen it a few times, then map samples against it
   task automatic run_frame();
      int spread, base, lo, hi, v, n_meas, n_map, k;
      case ($urandom_range(0, 3))
         0: spread = 0;
         1: spread = $urandom_range(1, 3);
         2: spread = $urandom_range(4, 300);
         default: spread = $urandom_range(301, 65535);
      endcase
      base = -32768 + int'($urandom_range(0, 65535 - spread));
      v = base + int'($urandom_range(0, spread));
      send_beat(OP_MEASURE, v[15:0], 1'b1);
      lo = v;
      hi = v;
      n_meas = $urandom_range(0, 6);
      for (k = 0; k < n_meas; k++) begin
         v = base + int'($urandom_range(0, spread));
         send_beat(OP_MEASURE, v[15:0], 1'b0);
         if (v < lo) lo = v;
         if (v > hi) hi = v;
      end
      n_map = $urandom_range(1, 12);
      for (k = 0; k < n_map; k++) begin
         case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? 32767 : -32768;
            1: v = int'($urandom_range(0, 65535)) - 32768;
            2: v = $urandom_range(0, 1) ? hi : lo;
            default: begin
               v = lo - 1 + int'($urandom_range(0, hi - lo + 2));
               if (v < -32768) v = -32768;
               if (v > 32767) v = 32767;
            end
         endcase
         send_beat(OP_MAP, v[15:0], 1'($urandom_range(0, 1)));
      end
   endtask

   // stimulus
   initial begin
      int phase, target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: flat start, extremes, saturation, first flag on a map
      write_mode(MODE_GREY);
      send_beat(OP_MAP,     16'h0000, 1'b1);
      send_beat(OP_MEASURE, 16'd100,  1'b0);
      send_beat(OP_MAP,     16'd50,   1'b0);
      send_beat(OP_MAP,     16'h8000, 1'b0);
      send_beat(OP_MAP,     16'h7fff, 1'b0);
      send_beat(OP_MEASURE, 16'h8000, 1'b1);
      send_beat(OP_MAP,     16'h8000, 1'b0);
      send_beat(OP_MEASURE, 16'h7fff, 1'b0);
      send_beat(OP_MAP,     16'h0000, 1'b0);
      send_beat(OP_MAP,     16'hffff, 1'b0);
      send_beat(OP_MAP,     16'h7ffe, 1'b1);
      send_beat(OP_MAP,     16'h8001, 1'b0);
      drain();
      write_mode(MODE_RGB);
      send_beat(OP_MAP,     16'h0000, 1'b0);
      send_beat(OP_MAP,     16'h0001, 1'b0);
      send_beat(OP_MAP,     16'h8000, 1'b0);
      send_beat(OP_MAP,     16'h7fff, 1'b0);
      send_beat(OP_MAP,     16'd12345, 1'b0);
      // span of one, then a flat range
      send_beat(OP_MEASURE, 16'd5, 1'b1);
      send_beat(OP_MEASURE, 16'd6, 1'b0);
      send_beat(OP_MAP,     16'd5, 1'b0);
      send_beat(OP_MAP,     16'd6, 1'b0);
      send_beat(OP_MAP,     16'd7, 1'b0);
      send_beat(OP_MEASURE, 16'd6, 1'b1);
      send_beat(OP_MAP,     16'd6, 1'b0);

      // random phases, mode rewritten while idle between them
      for (phase = 0; phase < 8; phase++) begin
         drain();
         if (phase == 0) write_mode(MODE_GREY);
         else if (phase == 1) write_mode(MODE_RGB);
         else write_mode(1'($urandom_range(0, 1)));
         send_calm = ($urandom_range(0, 3) == 0);
         rsp_calm  = ($urandom_range(0, 3) == 0);
         target = 25 + (phase + 1) * 230;
         while (items_sent < target) begin
            if ($urandom_range(0, 4) == 0)
               send_beat(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                         1'($urandom_range(0, 1)));
            else
               run_frame();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d request beats (%0d map), checked %0d response beats.",
               items_sent, sb.maps, sb.checked);
      $display("Mode phases: %0d grey, %0d RGB; %0d beats still expected.",
               grey_phases, rgb_phases, sb.colour_q.size());
      if (sb.errors == 0 && sb.colour_q.size() == 0) begin
         $display("** minmax_normalize_colour_map: PASSED **");
      end else begin
         $display("** minmax_normalize_colour_map: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("Timeout with %0d beats still expected.", sb.colour_q.size());
      $display("** minmax_normalize_colour_map: FAILED **");
      $finish;
   end

endmodule
